@@ design/rpv_pkg.sv @@
// ----------------------------------------------------------------------------
// rpv_pkg
// Shared types, constants and arithmetic helpers of the polygon vertex generator.
// ----------------------------------------------------------------------------
package rpv_pkg;

  localparam int unsigned CoordBits      = 16;
  localparam int unsigned RadiusBits     = 15;
  localparam int unsigned SideCountBits  = 7;
  localparam int unsigned DefMaxSides    = 64;
  localparam int unsigned DefAngleBits   = 16;

  // Q30 polynomial coefficients, sin(pi/4*z) and cos(pi/4*z)
  localparam logic signed [31:0] Q30One = 32'sd1073741824;
  localparam logic signed [31:0] SinTop = 32'sd336;
  localparam logic signed [31:0] CosTop = 32'sd3856;
  localparam logic signed [31:0] SinCoef [4] = '{
    32'sd39273, 32'sd2674041, 32'sd86699834, 32'sd843314857
  };
  localparam logic signed [31:0] CosCoef [4] = '{
    32'sd350033, 32'sd17023569, 32'sd331168976, 32'sd1073741824
  };

  typedef enum logic [1:0] {
    StIdle,
    StDivide,
    StIssue
  } rpv_state_e;

  typedef struct packed {
    logic signed [CoordBits-1:0]  cx;
    logic signed [CoordBits-1:0]  cy;
    logic signed [CoordBits-1:0]  cz;
    logic [RadiusBits-1:0]        rad;
    logic                         last;
  } vtx_side_t;

  // a*b/2^30, rounded to nearest, halves away from zero
  function automatic logic signed [31:0] mul_round30(input logic signed [31:0] a,
                                                     input logic signed [31:0] b);
    logic signed [63:0] p;
    logic signed [63:0] h;
    p = 64'(a) * 64'(b);
    h = 64'sd536870912 - 64'(p[63]);
    p = p + h;
    return p[61:30];
  endfunction

endpackage

@@ design/rpv_sincos.sv @@
// ----------------------------------------------------------------------------
// rpv_sincos
// Pipelined Q30 cosine/sine of a fraction-of-a-turn angle, Horner polynomials.
// ----------------------------------------------------------------------------
module rpv_sincos #(
  parameter int unsigned AngleBits = rpv_pkg::DefAngleBits
) (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   en_i,
  input  logic                   valid_i,
  input  logic [AngleBits-1:0]   angle_i,
  input  rpv_pkg::vtx_side_t     side_i,
  output logic                   valid_o,
  output logic signed [31:0]     cos_o,
  output logic signed [31:0]     sin_o,
  output rpv_pkg::vtx_side_t     side_o
);

  localparam int unsigned NumStg = 7;

  logic [NumStg-1:0]   valid_q;
  logic signed [31:0]  z_q [0:5];
  logic [1:0]          q_q [0:5];
  rpv_pkg::vtx_side_t  side_q [0:6];
  logic signed [31:0]  w_q [1:4];
  logic signed [31:0]  s_q [2:5];
  logic signed [31:0]  c_q [2:5];
  logic signed [31:0]  s_d [2:5];
  logic signed [31:0]  c_d [2:5];
  logic signed [31:0]  cos_q, sin_q, cos_d, sin_d;

  logic [31:0]         t_w, shifted_w;
  logic signed [31:0]  z_d;
  logic [1:0]          q_d;
  logic signed [31:0]  s_fin;

  always_comb begin
    t_w       = 32'(angle_i) << (32 - AngleBits);
    shifted_w = t_w + 32'h2000_0000;
    q_d       = shifted_w[31:30];
    z_d       = ($signed({2'b00, shifted_w[29:0]}) - 32'sd536870912) <<< 1;
  end

  always_comb begin
    for (int k = 2; k <= 5; k++) begin
      if (k == 2) begin
        s_d[k] = rpv_pkg::SinCoef[0] - rpv_pkg::mul_round30(w_q[1], rpv_pkg::SinTop);
        c_d[k] = rpv_pkg::CosCoef[0] - rpv_pkg::mul_round30(w_q[1], rpv_pkg::CosTop);
      end else begin
        s_d[k] = rpv_pkg::SinCoef[k-2] - rpv_pkg::mul_round30(w_q[k-1], s_q[k-1]);
        c_d[k] = rpv_pkg::CosCoef[k-2] - rpv_pkg::mul_round30(w_q[k-1], c_q[k-1]);
      end
    end
  end

  always_comb begin
    s_fin = rpv_pkg::mul_round30(z_q[5], s_q[5]);
    case (q_q[5])
      2'd0: begin
        cos_d = c_q[5];
        sin_d = s_fin;
      end
      2'd1: begin
        cos_d = -s_fin;
        sin_d = c_q[5];
      end
      2'd2: begin
        cos_d = -c_q[5];
        sin_d = -s_fin;
      end
      default: begin
        cos_d = s_fin;
        sin_d = -c_q[5];
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= '0;
    end else if (en_i) begin
      valid_q <= {valid_q[NumStg-2:0], valid_i};
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      z_q[0]    <= z_d;
      q_q[0]    <= q_d;
      side_q[0] <= side_i;
      for (int k = 1; k <= 5; k++) begin
        z_q[k] <= z_q[k-1];
        q_q[k] <= q_q[k-1];
      end
      for (int k = 1; k <= 6; k++) begin
        side_q[k] <= side_q[k-1];
      end
      w_q[1] <= rpv_pkg::mul_round30(z_q[0], z_q[0]);
      for (int k = 2; k <= 4; k++) begin
        w_q[k] <= w_q[k-1];
      end
      for (int k = 2; k <= 5; k++) begin
        s_q[k] <= s_d[k];
        c_q[k] <= c_d[k];
      end
      cos_q <= cos_d;
      sin_q <= sin_d;
    end
  end

  assign valid_o = valid_q[NumStg-1];
  assign cos_o   = cos_q;
  assign sin_o   = sin_q;
  assign side_o  = side_q[6];

endmodule

@@ design/regular_polygon_vertex_gen.sv @@
// ----------------------------------------------------------------------------
// regular_polygon_vertex_gen
// Emits the vertices of a regular polygon around a center, one per transfer.
// ----------------------------------------------------------------------------
// A request is taken only when the sequencer is idle. It first runs a
// restoring divider that finds 2^AngleBits / sides, then, while the output
// is not stalled, issues one vertex per cycle into a nine-stage arithmetic
// pipeline (angle split, six polynomial/multiply stages, radius scaling,
// saturating add and output register). The next request is taken once the
// last vertex has been issued, while its vertices may still be in the
// pipeline. Output stalls hold the whole pipe.
// A side count of zero is taken and produces no vertex.
module regular_polygon_vertex_gen #(
  parameter int unsigned MaxSides  = rpv_pkg::DefMaxSides,
  parameter int unsigned AngleBits = rpv_pkg::DefAngleBits
) (
  input  logic                                   clk_i,
  input  logic                                   rst_ni,
  input  logic                                   in_valid_i,
  output logic                                   in_ready_o,
  input  logic signed [rpv_pkg::CoordBits-1:0]   center_x_i,
  input  logic signed [rpv_pkg::CoordBits-1:0]   center_y_i,
  input  logic signed [rpv_pkg::CoordBits-1:0]   center_z_i,
  input  logic [rpv_pkg::RadiusBits-1:0]         radius_i,
  input  logic [rpv_pkg::SideCountBits-1:0]      side_count_i,
  output logic                                   out_valid_o,
  input  logic                                   out_ready_i,
  output logic signed [rpv_pkg::CoordBits-1:0]   vertex_x_o,
  output logic signed [rpv_pkg::CoordBits-1:0]   vertex_y_o,
  output logic signed [rpv_pkg::CoordBits-1:0]   vertex_z_o,
  output logic                                   last_vertex_o
);

  localparam int unsigned SideW = $clog2(MaxSides + 1);
  localparam int unsigned CntW  = $clog2(AngleBits + 1);
  localparam int unsigned ChkW  = AngleBits + SideW + 1;
  localparam int unsigned CW    = rpv_pkg::CoordBits;

  rpv_pkg::rpv_state_e state_q, state_d;

  logic [SideW-1:0]     n_in, n_q, idx_q, frac_q, rem_q, rem_nx, frac_nx;
  logic [CntW-1:0]      cnt_q;
  logic [AngleBits:0]   quo_q, ang_q, ang_nx;
  logic [SideW:0]       rem_sh, fsum;
  logic                 qbit, carry, issue, en, in_xfer;
  logic signed [CW-1:0] cx_q, cy_q, cz_q;
  logic [rpv_pkg::RadiusBits-1:0] rad_q;
  rpv_pkg::vtx_side_t   side_in, side7, side8_q;

  logic                 sc_valid, v8_q, out_valid_q;
  logic signed [31:0]   cos_w, sin_w, rad_w, offx_w, offy_w;
  logic signed [17:0]   offx_q, offy_q, sumx, sumy;
  logic signed [CW-1:0] vx_q, vy_q, vz_q, vx_d, vy_d;
  logic                 last_q;
  logic [ChkW-1:0]      chk_prod;

  assign en      = !out_valid_q || out_ready_i;
  assign in_xfer = in_valid_i && in_ready_o;

  always_comb begin
    if (side_count_i > rpv_pkg::SideCountBits'(MaxSides)) begin
      n_in = SideW'(MaxSides);
    end else begin
      n_in = SideW'(side_count_i);
    end
  end

  // divider step: dividend is 2^AngleBits, one bit per cycle
  always_comb begin
    rem_sh = {rem_q, (cnt_q == CntW'(AngleBits))};
    qbit   = rem_sh >= {1'b0, n_q};
    rem_nx = qbit ? SideW'(rem_sh - {1'b0, n_q}) : rem_sh[SideW-1:0];
  end

  // angle walk: a += q0, plus one when the remainder wraps
  always_comb begin
    fsum    = {1'b0, frac_q} + {1'b0, rem_q};
    carry   = fsum >= {1'b0, n_q};
    frac_nx = carry ? SideW'(fsum - {1'b0, n_q}) : fsum[SideW-1:0];
    ang_nx  = ang_q + quo_q + (AngleBits + 1)'(carry);
  end

  always_comb begin
    state_d    = state_q;
    in_ready_o = 1'b0;
    issue      = 1'b0;
    case (state_q)
      rpv_pkg::StIdle: begin
        in_ready_o = 1'b1;
        if (in_valid_i && (n_in != '0)) begin
          state_d = rpv_pkg::StDivide;
        end
      end
      rpv_pkg::StDivide: begin
        if (cnt_q == '0) begin
          state_d = rpv_pkg::StIssue;
        end
      end
      rpv_pkg::StIssue: begin
        if (en) begin
          issue = 1'b1;
          if (idx_q == n_q - SideW'(1)) begin
            state_d = rpv_pkg::StIdle;
          end
        end
      end
      default: begin
        state_d = rpv_pkg::StIdle;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= rpv_pkg::StIdle;
      n_q     <= '0;
      cnt_q   <= '0;
      rem_q   <= '0;
      quo_q   <= '0;
      idx_q   <= '0;
      ang_q   <= '0;
      frac_q  <= '0;
    end else begin
      state_q <= state_d;
      if (in_xfer) begin
        n_q    <= n_in;
        cnt_q  <= CntW'(AngleBits);
        rem_q  <= '0;
        quo_q  <= '0;
        idx_q  <= '0;
        ang_q  <= '0;
        frac_q <= '0;
      end else if (state_q == rpv_pkg::StDivide) begin
        rem_q <= rem_nx;
        quo_q <= {quo_q[AngleBits-1:0], qbit};
        cnt_q <= cnt_q - CntW'(1);
      end else if (issue) begin
        idx_q  <= idx_q + SideW'(1);
        ang_q  <= ang_nx;
        frac_q <= frac_nx;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_xfer) begin
      cx_q  <= center_x_i;
      cy_q  <= center_y_i;
      cz_q  <= center_z_i;
      rad_q <= radius_i;
    end
  end

  always_comb begin
    side_in.cx   = cx_q;
    side_in.cy   = cy_q;
    side_in.cz   = cz_q;
    side_in.rad  = rad_q;
    side_in.last = (idx_q == n_q - SideW'(1));
  end

  rpv_sincos #(
    .AngleBits(AngleBits)
  ) u_sincos (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (en),
    .valid_i (issue),
    .angle_i (ang_q[AngleBits-1:0]),
    .side_i  (side_in),
    .valid_o (sc_valid),
    .cos_o   (cos_w),
    .sin_o   (sin_w),
    .side_o  (side7)
  );

  // radius scaling
  always_comb begin
    rad_w  = $signed({17'd0, side7.rad});
    offx_w = rpv_pkg::mul_round30(rad_w, cos_w);
    offy_w = rpv_pkg::mul_round30(rad_w, sin_w);
  end

  // saturating add
  always_comb begin
    sumx = 18'(side8_q.cx) + offx_q;
    sumy = 18'(side8_q.cy) + offy_q;
    if (sumx > 18'sd32767) begin
      vx_d = 16'sh7FFF;
    end else if (sumx < -18'sd32768) begin
      vx_d = 16'sh8000;
    end else begin
      vx_d = sumx[CW-1:0];
    end
    if (sumy > 18'sd32767) begin
      vy_d = 16'sh7FFF;
    end else if (sumy < -18'sd32768) begin
      vy_d = 16'sh8000;
    end else begin
      vy_d = sumy[CW-1:0];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v8_q        <= 1'b0;
      out_valid_q <= 1'b0;
    end else if (en) begin
      v8_q        <= sc_valid;
      out_valid_q <= v8_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      offx_q  <= offx_w[17:0];
      offy_q  <= offy_w[17:0];
      side8_q <= side7;
      vx_q    <= vx_d;
      vy_q    <= vy_d;
      vz_q    <= side8_q.cz;
      last_q  <= side8_q.last;
    end
  end

  assign out_valid_o   = out_valid_q;
  assign vertex_x_o    = vx_q;
  assign vertex_y_o    = vy_q;
  assign vertex_z_o    = vz_q;
  assign last_vertex_o = last_q;

  assign chk_prod = ChkW'(quo_q) * ChkW'(n_q) + ChkW'(rem_q);

  a_div_exact: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == rpv_pkg::StDivide) && (cnt_q == '0)
      |=> chk_prod == (ChkW'(1) << AngleBits))
    else $error("divider result inconsistent");

  a_walk_bounds: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == rpv_pkg::StIssue) |-> (frac_q < n_q) && !ang_q[AngleBits])
    else $error("angle walk out of range");

  a_idx_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == rpv_pkg::StIssue) |-> (idx_q < n_q))
    else $error("vertex index beyond side count");

endmodule

@@ tb/tb_regular_polygon_vertex_gen.sv @@
// ----------------------------------------------------------------------------
// tb_regular_polygon_vertex_gen
// Self-checking bench for the polygon vertex generator: polygon requests are
// sent over valid/ready, each vertex is predicted in fixed point and every
// output transfer is compared field by field against the oldest prediction.
// ----------------------------------------------------------------------------
module tb_regular_polygon_vertex_gen;

  localparam int unsigned MaxSides   = 64;
  localparam int unsigned CycleLimit = 2000000;

  typedef struct {
    logic signed [15:0] x;
    logic signed [15:0] y;
    logic signed [15:0] z;
    logic               last;
  } vertex_t;

  logic                                 clk_i;
  logic                                 rst_ni;
  logic                                 in_valid_i;
  logic                                 in_ready_o;
  logic signed [rpv_pkg::CoordBits-1:0] center_x_i;
  logic signed [rpv_pkg::CoordBits-1:0] center_y_i;
  logic signed [rpv_pkg::CoordBits-1:0] center_z_i;
  logic [rpv_pkg::RadiusBits-1:0]       radius_i;
  logic [rpv_pkg::SideCountBits-1:0]    side_count_i;
  logic                                 out_valid_o;
  logic                                 out_ready_i;
  logic signed [rpv_pkg::CoordBits-1:0] vertex_x_o;
  logic signed [rpv_pkg::CoordBits-1:0] vertex_y_o;
  logic signed [rpv_pkg::CoordBits-1:0] vertex_z_o;
  logic                                 last_vertex_o;

  vertex_t     vertex_q[$];
  int unsigned failures;
  int unsigned cycles;
  int unsigned send_idle_pct;
  int unsigned recv_idle_pct;

  regular_polygon_vertex_gen i_dut (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (in_valid_i),
    .in_ready_o   (in_ready_o),
    .center_x_i   (center_x_i),
    .center_y_i   (center_y_i),
    .center_z_i   (center_z_i),
    .radius_i     (radius_i),
    .side_count_i (side_count_i),
    .out_valid_o  (out_valid_o),
    .out_ready_i  (out_ready_i),
    .vertex_x_o   (vertex_x_o),
    .vertex_y_o   (vertex_y_o),
    .vertex_z_o   (vertex_z_o),
    .last_vertex_o(last_vertex_o)
  );

  initial begin
    clk_i = 1'b0;
    forever #10 clk_i = ~clk_i;
  end

  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles > CycleLimit) begin
      $display("Test completed with failures");
      $finish;
    end
  end

  // round(a*b / 2^30), halves away from zero
  function automatic longint mul_q30(longint a, longint b);
    longint unsigned ua;
    longint unsigned ub;
    longint unsigned m;
    ua = (a < 0) ? longint'(-a) : a;
    ub = (b < 0) ? longint'(-b) : b;
    m  = (ua * ub + 64'd536870912) >> 30;
    return ((a < 0) != (b < 0)) ? -longint'(m) : longint'(m);
  endfunction

  function automatic logic signed [15:0] sat_coord(longint v);
    if (v > 32767) return 16'sh7fff;
    if (v < -32768) return 16'sh8000;
    return v[15:0];
  endfunction

  task automatic cos_sin_turn(input logic [31:0] t, output longint c_out,
                              output longint s_out);
    logic [31:0] sh;
    longint      z;
    longint      w;
    longint      s;
    longint      c;
    sh = t + 32'h2000_0000;
    z  = 2 * (longint'(sh[29:0]) - 64'sd536870912);
    w  = mul_q30(z, z);
    s  = rpv_pkg::SinTop;
    c  = rpv_pkg::CosTop;
    for (int k = 0; k < 4; k++) begin
      s = longint'(rpv_pkg::SinCoef[k]) - mul_q30(w, s);
      c = longint'(rpv_pkg::CosCoef[k]) - mul_q30(w, c);
    end
    s = mul_q30(z, s);
    case (sh[31:30])
      2'd0: begin c_out = c;  s_out = s;  end
      2'd1: begin c_out = -s; s_out = c;  end
      2'd2: begin c_out = -c; s_out = -s; end
      default: begin c_out = s; s_out = -c; end
    endcase
  endtask

  task automatic predict_polygon(input logic signed [15:0] cx, input logic signed [15:0] cy,
                                 input logic signed [15:0] cz, input logic [14:0] rad,
                                 input logic [6:0] sides);
    int unsigned n;
    logic [31:0] ang;
    longint      cv;
    longint      sv;
    vertex_t     v;
    n = (sides > MaxSides) ? MaxSides : sides;
    for (int unsigned i = 0; i < n; i++) begin
      ang = ((i << 16) / n) << 16;
      cos_sin_turn(ang, cv, sv);
      v.x    = sat_coord(longint'(cx) + mul_q30(longint'(rad), cv));
      v.y    = sat_coord(longint'(cy) + mul_q30(longint'(rad), sv));
      v.z    = cz;
      v.last = (i + 1 == n);
      vertex_q = {vertex_q, v};
    end
  endtask

  task automatic report_mismatch(input string what, input int exp_v, input int got_v);
    $display("mismatch %s: expected %0d got %0d", what, exp_v, got_v);
    failures++;
  endtask

  always @(posedge clk_i) begin
    out_ready_i <= ($urandom_range(99) >= recv_idle_pct);
  end

  always @(posedge clk_i) begin
    vertex_t e;
    if (rst_ni && out_valid_o && out_ready_i) begin
      if (vertex_q.size() == 0) begin
        report_mismatch("unexpected vertex, pending", 0, 1);
      end else begin
        e = vertex_q.pop_front();
        if (vertex_x_o !== e.x) report_mismatch("vertex_x", e.x, vertex_x_o);
        if (vertex_y_o !== e.y) report_mismatch("vertex_y", e.y, vertex_y_o);
        if (vertex_z_o !== e.z) report_mismatch("vertex_z", e.z, vertex_z_o);
        if (last_vertex_o !== e.last) report_mismatch("last_vertex", e.last, last_vertex_o);
      end
    end
  end

  task automatic send_request(input logic signed [15:0] cx, input logic signed [15:0] cy,
                              input logic signed [15:0] cz, input logic [14:0] rad,
                              input logic [6:0] sides);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    in_valid_i   <= 1'b1;
    center_x_i   <= cx;
    center_y_i   <= cy;
    center_z_i   <= cz;
    radius_i     <= rad;
    side_count_i <= sides;
    do @(posedge clk_i); while (!in_ready_o);
    predict_polygon(cx, cy, cz, rad, sides);
  endtask

  task automatic test_directed;
    send_request(16'sd0, 16'sd0, 16'sd0, 15'd32767, 7'd4);
    send_request(16'sd0, 16'sd0, 16'sd5, 15'd100, 7'd0);
    send_request(16'sd100, -16'sd100, 16'sd7, 15'd1000, 7'd1);
    send_request(16'sd0, 16'sd0, -16'sd1, 15'd20000, 7'd2);
    send_request(16'sd1, 16'sd2, 16'sd3, 15'd12345, 7'd3);
    send_request(16'sh7fff, 16'sh7fff, 16'sh7fff, 15'd32767, 7'd8);
    send_request(16'sh8000, 16'sh8000, 16'sh8000, 15'd32767, 7'd8);
    send_request(16'sh7fff, 16'sh8000, 16'sd0, 15'd0, 7'd5);
    send_request(-16'sd5000, 16'sd5000, 16'sd0, 15'd32767, 7'd64);
    send_request(16'sd0, 16'sd0, 16'sh5555, 15'd16384, 7'd65);
    send_request(16'sd0, 16'sd0, -16'sh5556, 15'd1, 7'd127);
    send_request(16'sd20000, -16'sd20000, 16'sd0, 15'd30000, 7'd6);
    send_request(16'sd0, 16'sd0, 16'sd0, 15'd32767, 7'd7);
  endtask

  task automatic test_random(input int unsigned count);
    logic [6:0] sides;
    for (int unsigned k = 0; k < count; k++) begin
      sides = ($urandom_range(9) == 0) ? 7'($urandom_range(127)) : 7'($urandom_range(1, 16));
      send_request(16'($urandom), 16'($urandom), 16'($urandom),
                   15'($urandom), sides);
    end
  endtask

  initial begin
    failures      = 0;
    cycles        = 0;
    send_idle_pct = 38;
    recv_idle_pct = 73;
    rst_ni        <= 1'b0;
    in_valid_i    <= 1'b0;
    out_ready_i   <= 1'b0;
    center_x_i    <= '0;
    center_y_i    <= '0;
    center_z_i    <= '0;
    radius_i      <= '0;
    side_count_i  <= '0;
    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_directed();
    test_random(80);
    send_idle_pct = 73;
    recv_idle_pct = 38;
    test_random(80);
    send_idle_pct = 0;
    recv_idle_pct = 0;
    test_random(90);
    in_valid_i <= 1'b0;
    while (vertex_q.size() != 0) @(posedge clk_i);
    repeat (40) @(posedge clk_i);
    if (failures == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule
